// ===== src/mwa_pkg.sv =====
// ----------------------------------------------------------------------------
// mwa_pkg: shared types and codes for the memory with atomic operations.
// Holds the request and result structs, opcodes, atomic codes and status codes.
// ----------------------------------------------------------------------------
package mwa_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_AMO   = 2'd2;
	localparam logic [1:0] OP_OTHER = 2'd3;

	localparam logic [3:0] AMO_SWAP = 4'd0;
	localparam logic [3:0] AMO_ADD  = 4'd1;
	localparam logic [3:0] AMO_XOR  = 4'd2;
	localparam logic [3:0] AMO_AND  = 4'd3;
	localparam logic [3:0] AMO_OR   = 4'd4;
	localparam logic [3:0] AMO_MIN  = 4'd5;
	localparam logic [3:0] AMO_MAX  = 4'd6;
	localparam logic [3:0] AMO_MINU = 4'd7;
	localparam logic [3:0] AMO_MAXU = 4'd8;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ADDR    = 2'd1;
	localparam logic [1:0] ST_GENERIC = 2'd2;
	localparam logic [1:0] ST_CMD     = 2'd3;

	localparam int unsigned MaxBytes = 8;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  amo_op;
		logic [31:0] address;
		logic [3:0]  length;
		logic [63:0] write_data;
		logic        enables_present;
		logic [3:0]  enable_length;
		logic [7:0]  enable_pattern;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic [1:0]  status;
		logic [3:0]  bytes_done;
	} rsp_t;

	// Classified command handed from the front to the back.
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_READ,
		CMD_WRITE,
		CMD_AMO
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [1:0]  status;
		logic [3:0]  length;
		logic [3:0]  amo_op;
		logic [31:0] address;
		logic [63:0] write_data;
		logic [7:0]  byte_en;
	} work_t;

endpackage

// ===== src/memory_with_atomic_ops_unit.sv =====
// ----------------------------------------------------------------------------
// memory_with_atomic_ops_unit: byte memory with atomic read-modify-write.
// The back end takes, reads and executes one request at a time, using the
// single memory row port per bank; it takes no new request before the last
// one is answered, while the two-entry queue in front accepts more.
// Reset clears control and queue state; memory contents are not cleared.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module memory_with_atomic_ops_unit #(
	parameter int unsigned MEM_BYTES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mwa_pkg::req_t  request,
	output logic           done,
	output mwa_pkg::rsp_t  result
);

	mwa_pkg::work_t fe_work, q_work;
	logic           q_full, q_ne, q_pop, accept;

	// A request is taken whenever the queue has room.
	assign busy   = q_full;
	assign accept = start && !busy;

	// The front classifies and checks the request combinationally.
	mwa_front #(.MEM_BYTES(MEM_BYTES)) u_front (
		.req  (request),
		.work (fe_work)
	);

	mwa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (fe_work),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_ne),
		.pop_data  (q_work)
	);

	// The back end runs one item at a time, in order, against the memory.
	mwa_back #(.MEM_BYTES(MEM_BYTES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.work_valid   (q_ne),
		.work         (q_work),
		.work_pop     (q_pop),
		.result_valid (done),
		.result       (result)
	);

endmodule

// ===== src/mwa_front.sv =====
// ----------------------------------------------------------------------------
// mwa_front: request checker and classifier.
// Runs the range and enable checks and builds the per-byte write enables.
// ----------------------------------------------------------------------------
module mwa_front #(
	parameter int unsigned MEM_BYTES = 65536
) (
	input  mwa_pkg::req_t  req,
	output mwa_pkg::work_t work
);

	logic [32:0] end_addr;
	logic        addr_bad;
	logic [7:0]  en;
	logic [3:0]  k;

	always_comb begin
		end_addr = {1'b0, req.address} + {29'd0, req.length};
		addr_bad = ({1'b0, req.address} >= 33'(MEM_BYTES)) || (end_addr > 33'(MEM_BYTES));
		// Repeat the pattern every enable_length bytes; k tracks i mod enable_length.
		k = 4'd0;
		for (int i = 0; i < 8; i++) begin
			en[i] = (k < 4'd8) ? req.enable_pattern[k[2:0]] : 1'b0;
			k = (k + 4'd1 >= req.enable_length) ? 4'd0 : k + 4'd1;
		end
		work.length     = req.length;
		work.amo_op     = req.amo_op;
		work.address    = req.address;
		work.write_data = req.write_data;
		work.byte_en    = req.enables_present ? en : 8'hFF;
		work.cmd        = mwa_pkg::CMD_NONE;
		work.status     = mwa_pkg::ST_OK;
		priority if (addr_bad) begin
			work.status = mwa_pkg::ST_ADDR;
		end else if (req.enables_present && req.enable_length == 4'd0) begin
			work.status = mwa_pkg::ST_GENERIC;
		end else if (req.length > 4'(mwa_pkg::MaxBytes)) begin
			work.status = mwa_pkg::ST_GENERIC;
		end else if (req.opcode == mwa_pkg::OP_AMO) begin
			if (req.enables_present || (req.length != 4'd4 && req.length != 4'd8))
				work.status = mwa_pkg::ST_CMD;
			else
				work.cmd = mwa_pkg::CMD_AMO;
		end else if (req.opcode == mwa_pkg::OP_READ) begin
			work.cmd = mwa_pkg::CMD_READ;
		end else if (req.opcode == mwa_pkg::OP_WRITE) begin
			work.cmd = mwa_pkg::CMD_WRITE;
		end else begin
			work.status = mwa_pkg::ST_CMD;
		end
	end

endmodule

// ===== src/mwa_queue.sv =====
// ----------------------------------------------------------------------------
// mwa_queue: two-entry queue between the front and the back.
// Decouples request acceptance from execution.
// ----------------------------------------------------------------------------
module mwa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mwa_pkg::work_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output mwa_pkg::work_t pop_data
);

	mwa_pkg::work_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(pop && !not_empty))
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) !(push && full && !pop))
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ===== src/mwa_back.sv =====
// ----------------------------------------------------------------------------
// mwa_back: executor with the byte memory and the atomic ALU.
// Each item reads the eight byte lanes, then writes back and answers.
// ----------------------------------------------------------------------------
module mwa_back #(
	parameter int unsigned MEM_BYTES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           work_valid,
	input  mwa_pkg::work_t work,
	output logic           work_pop,
	output logic           result_valid,
	output mwa_pkg::rsp_t  result
);

	localparam int unsigned AW = $clog2(MEM_BYTES);
	// Bank b holds bytes whose address mod 8 equals b.
	localparam int unsigned RowW = (AW > 3) ? AW - 3 : 1;
	localparam int unsigned Rows = (MEM_BYTES + 7) / 8;

	typedef enum logic [1:0] { S_IDLE, S_READ, S_EXEC } state_t;

	state_t         state_q;
	mwa_pkg::work_t w_q;
	logic [7:0]     bank_q [8][Rows];
	logic [7:0]     rd_q [8];
	logic [RowW-1:0] row_of [8];
	logic [63:0]    old_val, opd, new_val, res_rd;
	logic [63:0]    sign;
	logic           wide;
	logic [31:0]    base_row;
	logic [2:0]     off;
	logic [7:0]     wr_en;
	logic [63:0]    wr_val;

	assign off      = w_q.address[2:0];
	assign base_row = w_q.address >> 3;
	assign work_pop = (state_q == S_IDLE) && work_valid;

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			// Byte i = (b - off) mod 8 lands in bank b, one row later if it wrapped.
			row_of[b] = (3'(b) < off) ? RowW'(base_row + 32'd1) : RowW'(base_row);
		end
	end

	always_comb begin
		wide = (w_q.length == 4'd8);
		sign = wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
		old_val = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < w_q.length) old_val[8*i +: 8] = rd_q[3'(off + 3'(i))];
		end
		opd = wide ? w_q.write_data : {32'd0, w_q.write_data[31:0]};
		unique case (w_q.amo_op)
			mwa_pkg::AMO_SWAP: new_val = opd;
			mwa_pkg::AMO_ADD:  new_val = old_val + opd;
			mwa_pkg::AMO_XOR:  new_val = old_val ^ opd;
			mwa_pkg::AMO_AND:  new_val = old_val & opd;
			mwa_pkg::AMO_OR:   new_val = old_val | opd;
			mwa_pkg::AMO_MIN:  new_val = ((old_val ^ sign) < (opd ^ sign)) ? old_val : opd;
			mwa_pkg::AMO_MAX:  new_val = ((old_val ^ sign) > (opd ^ sign)) ? old_val : opd;
			mwa_pkg::AMO_MINU: new_val = (old_val < opd) ? old_val : opd;
			mwa_pkg::AMO_MAXU: new_val = (old_val > opd) ? old_val : opd;
			default:           new_val = old_val;
		endcase
		wr_en  = '0;
		wr_val = (w_q.cmd == mwa_pkg::CMD_AMO) ? new_val : w_q.write_data;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < w_q.length &&
			    (w_q.cmd == mwa_pkg::CMD_AMO ||
			     (w_q.cmd == mwa_pkg::CMD_WRITE && w_q.byte_en[i])))
				wr_en[i] = 1'b1;
		end
		res_rd = (w_q.cmd == mwa_pkg::CMD_READ || w_q.cmd == mwa_pkg::CMD_AMO) ?
			old_val : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (work_valid) state_q <= S_READ;
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					state_q           <= S_IDLE;
					result_valid      <= 1'b1;
					result.read_data  <= res_rd;
					result.status     <= w_q.status;
					result.bytes_done <= (w_q.status == mwa_pkg::ST_OK) ? w_q.length : 4'd0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (work_pop) w_q <= work;
	end

	for (genvar b = 0; b < 8; b++) begin : g_bank
		always_ff @(posedge clk) begin
			if (state_q == S_READ) rd_q[b] <= bank_q[b][row_of[b]];
			if (state_q == S_EXEC && wr_en[3'(3'(b) - off)])
				bank_q[b][row_of[b]] <= wr_val[8*(3'(3'(b) - off)) +: 8];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> $past(state_q) == S_EXEC)
		else $error("result without execute step");
	assert property (@(posedge clk) disable iff (!arst_n) work_pop |=> state_q == S_READ)
		else $error("pop did not start an item");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && w_q.status != mwa_pkg::ST_OK) |-> wr_en == 8'd0)
		else $error("failed request writes memory");

endmodule

// ===== tb/tb_memory_with_atomic_ops_unit.sv =====
// ----------------------------------------------------------------------------
// tb_memory_with_atomic_ops_unit: self-checking bench for the atomic memory.
// A short table of hand-picked requests, then random requests. Random traffic
// lands mostly in a small window at each end of the memory. Every result is
// checked against a hand-typed want or a byte-level memory image in this bench.
// ----------------------------------------------------------------------------
module tb_memory_with_atomic_ops_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MemBytes = 65536;
	localparam int RandomRequests = 1950;
	// An atomic code with no defined operation.
	localparam logic [3:0] AmoUnknown = 4'd15;

	// One row of the directed table. When has_want is set, the result is typed
	// in by hand; otherwise the memory image predicts it.
	typedef struct {
		mwa_pkg::req_t rq;
		bit            has_want;
		mwa_pkg::rsp_t want;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic          done;
	mwa_pkg::req_t request;
	mwa_pkg::rsp_t result;

	// Byte image of the memory, and a flag per byte that says it has been
	// written. A read must never touch a byte whose flag is clear.
	logic [7:0] mem_image [MemBytes];
	bit         mem_written [MemBytes];

	mwa_pkg::rsp_t pending_rsp [$];
	dir_row_t      dir_tbl [$];
	int            errors = 0;

	memory_with_atomic_ops_unit #(
		.MEM_BYTES(MemBytes)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard limit on the run. The slowest correct run stays far below it.
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic mwa_pkg::req_t mk(input logic [1:0] op, input logic [3:0] amo,
			input logic [31:0] addr, input logic [3:0] len, input logic [63:0] wd,
			input logic ep, input logic [3:0] el, input logic [7:0] pat);
		mwa_pkg::req_t r;
		r.opcode          = op;
		r.amo_op          = amo;
		r.address         = addr;
		r.length          = len;
		r.write_data      = wd;
		r.enables_present = ep;
		r.enable_length   = el;
		r.enable_pattern  = pat;
		return r;
	endfunction

	// Applies one request to the memory image and gives the result it causes.
	function automatic mwa_pkg::rsp_t mem_apply(input mwa_pkg::req_t rq);
		mwa_pkg::rsp_t r;
		logic [63:0]   old_val;
		logic [63:0]   opd;
		logic [63:0]   new_val;
		logic [63:0]   mask;
		logic [63:0]   sgn;
		logic [32:0]   top;
		bit            wide;
		bit            en;
		int            k;
		r = '0;
		old_val = '0;
		top = {1'b0, rq.address} + {29'd0, rq.length};
		if (rq.address >= MemBytes || top > MemBytes) begin
			r.status = mwa_pkg::ST_ADDR;
		end else if (rq.enables_present && rq.enable_length == 0) begin
			r.status = mwa_pkg::ST_GENERIC;
		end else if (rq.length > mwa_pkg::MaxBytes) begin
			r.status = mwa_pkg::ST_GENERIC;
		end else if (rq.opcode == mwa_pkg::OP_AMO) begin
			if (rq.enables_present || (rq.length != 4 && rq.length != 8)) begin
				r.status = mwa_pkg::ST_CMD;
			end else begin
				wide = (rq.length == 8);
				mask = wide ? '1 : 64'h0000_0000_ffff_ffff;
				sgn  = wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
				for (int i = 0; i < rq.length; i++)
					old_val[8*i +: 8] = mem_image[rq.address + i];
				opd = rq.write_data & mask;
				// Flipping the sign bit lets an unsigned compare give the signed order.
				case (rq.amo_op)
					mwa_pkg::AMO_SWAP: new_val = opd;
					mwa_pkg::AMO_ADD:  new_val = (old_val + opd) & mask;
					mwa_pkg::AMO_XOR:  new_val = old_val ^ opd;
					mwa_pkg::AMO_AND:  new_val = old_val & opd;
					mwa_pkg::AMO_OR:   new_val = old_val | opd;
					mwa_pkg::AMO_MIN:  new_val = ((old_val ^ sgn) < (opd ^ sgn)) ? old_val : opd;
					mwa_pkg::AMO_MAX:  new_val = ((old_val ^ sgn) > (opd ^ sgn)) ? old_val : opd;
					mwa_pkg::AMO_MINU: new_val = (old_val < opd) ? old_val : opd;
					mwa_pkg::AMO_MAXU: new_val = (old_val > opd) ? old_val : opd;
					default:           new_val = old_val;
				endcase
				for (int i = 0; i < rq.length; i++)
					mem_image[rq.address + i] = new_val[8*i +: 8];
				r.read_data = old_val;
			end
		end else if (rq.opcode == mwa_pkg::OP_READ) begin
			for (int i = 0; i < rq.length; i++)
				r.read_data[8*i +: 8] = mem_image[rq.address + i];
		end else if (rq.opcode == mwa_pkg::OP_WRITE) begin
			for (int i = 0; i < rq.length; i++) begin
				en = 1'b1;
				if (rq.enables_present) begin
					// Pattern entries past bit seven count as disabled.
					k = i % rq.enable_length;
					en = (k < 8) && rq.enable_pattern[k];
				end
				if (en) begin
					mem_image[rq.address + i] = rq.write_data[8*i +: 8];
					mem_written[rq.address + i] = 1'b1;
				end
			end
		end else begin
			r.status = mwa_pkg::ST_CMD;
		end
		if (r.status == mwa_pkg::ST_OK)
			r.bytes_done = rq.length;
		return r;
	endfunction

	// True when the request would successfully read a byte never written.
	function automatic bit reads_unwritten(input mwa_pkg::req_t rq);
		logic [32:0] top;
		bit          reads;
		top = {1'b0, rq.address} + {29'd0, rq.length};
		if (rq.address >= MemBytes || top > MemBytes || rq.length > mwa_pkg::MaxBytes)
			return 1'b0;
		if (rq.enables_present && rq.enable_length == 0)
			return 1'b0;
		reads = (rq.opcode == mwa_pkg::OP_READ) || (rq.opcode == mwa_pkg::OP_AMO
			&& !rq.enables_present && (rq.length == 4 || rq.length == 8));
		if (!reads)
			return 1'b0;
		for (int i = 0; i < rq.length; i++)
			if (!mem_written[rq.address + i])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic mwa_pkg::req_t random_request();
		mwa_pkg::req_t rq;
		int            sel;
		rq.opcode = 2'($urandom_range(0, 3));
		sel = $urandom_range(0, 99);
		rq.amo_op = (sel < 85) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
		sel = $urandom_range(0, 99);
		if (sel < 8)
			rq.address = $urandom();
		else if (sel < 20)
			rq.address = MemBytes - 16 + $urandom_range(0, 15);
		else if (sel < 24)
			rq.address = MemBytes + $urandom_range(0, 4);
		else
			rq.address = $urandom_range(0, 63);
		sel = $urandom_range(0, 99);
		if (sel < 30)
			rq.length = 4'd8;
		else if (sel < 50)
			rq.length = 4'd4;
		else if (sel < 88)
			rq.length = 4'($urandom_range(0, 8));
		else
			rq.length = 4'($urandom_range(9, 15));
		rq.write_data = {$urandom(), $urandom()};
		rq.enables_present = ($urandom_range(0, 99) < 25);
		rq.enable_length = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(1, 8));
		rq.enable_pattern = 8'($urandom_range(0, 255));
		// A read of unwritten memory is not allowed, so such a request becomes
		// a plain write that fills those bytes instead.
		if (reads_unwritten(rq)) begin
			rq.opcode = mwa_pkg::OP_WRITE;
			rq.enables_present = 1'b0;
		end
		return rq;
	endfunction

	// Idle cycles before a request: mostly none, some short, a few long, and
	// whole stretches of back-to-back traffic.
	function automatic int pick_gap(input int n);
		int sel;
		if ((n % 300) < 60)
			return 0;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Results are sampled at the clock edge, so they reflect the cycle that
	// this edge ends.
	always @(posedge clk) begin
		mwa_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result", result.read_data, 64'd0);
			end else begin
				want = pending_rsp.pop_front();
				if (result.read_data !== want.read_data)
					report_mismatch("read_data", result.read_data, want.read_data);
				if (result.status !== want.status)
					report_mismatch("status", 64'(result.status), 64'(want.status));
				if (result.bytes_done !== want.bytes_done)
					report_mismatch("bytes_done", 64'(result.bytes_done),
						64'(want.bytes_done));
			end
		end
	end

	initial begin
		mwa_pkg::req_t rq;
		mwa_pkg::rsp_t predicted;
		dir_row_t      row;
		int            total;
		int            gap;
		int            guard;

		// Directed table. Writes come before any read of the same bytes.
		dir_tbl.push_back('{mk(mwa_pkg::OP_WRITE, mwa_pkg::AMO_SWAP, 32'd0, 4'd8,
			64'h8877_6655_4433_2211, 1'b0, 4'd0, 8'h00), 1'b1,
			'{64'h0, mwa_pkg::ST_OK, 4'd8}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_READ, mwa_pkg::AMO_SWAP, 32'd0, 4'd8, 64'h0,
			1'b1, 4'd3, 8'h00), 1'b1, '{64'h8877_6655_4433_2211, mwa_pkg::ST_OK, 4'd8}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_WRITE, mwa_pkg::AMO_SWAP, MemBytes - 8, 4'd8,
			'1, 1'b0, 4'd0, 8'h00), 1'b1, '{64'h0, mwa_pkg::ST_OK, 4'd8}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_READ, mwa_pkg::AMO_SWAP, MemBytes - 8, 4'd8,
			64'h0, 1'b0, 4'd0, 8'h00), 1'b1, '{'1, mwa_pkg::ST_OK, 4'd8}});
		// Range errors, including one of length zero just past the end.
		dir_tbl.push_back('{mk(mwa_pkg::OP_READ, mwa_pkg::AMO_SWAP, MemBytes, 4'd0, 64'h0,
			1'b0, 4'd0, 8'h00), 1'b1, '{64'h0, mwa_pkg::ST_ADDR, 4'd0}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_WRITE, mwa_pkg::AMO_SWAP, MemBytes - 4, 4'd8,
			'1, 1'b0, 4'd0, 8'h00), 1'b1, '{64'h0, mwa_pkg::ST_ADDR, 4'd0}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_AMO, mwa_pkg::AMO_ADD, 32'hffff_ffff, 4'd15,
			'1, 1'b1, 4'd0, 8'hff), 1'b1, '{64'h0, mwa_pkg::ST_ADDR, 4'd0}});
		// Generic errors: enables with no length, and an oversized access.
		dir_tbl.push_back('{mk(mwa_pkg::OP_WRITE, mwa_pkg::AMO_SWAP, 32'd0, 4'd8, 64'h0,
			1'b1, 4'd0, 8'hff), 1'b1, '{64'h0, mwa_pkg::ST_GENERIC, 4'd0}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_READ, mwa_pkg::AMO_SWAP, 32'd0, 4'd15, 64'h0,
			1'b0, 4'd0, 8'h00), 1'b1, '{64'h0, mwa_pkg::ST_GENERIC, 4'd0}});
		// Command errors: other command, short atomic, atomic with enables.
		dir_tbl.push_back('{mk(mwa_pkg::OP_OTHER, mwa_pkg::AMO_SWAP, 32'd0, 4'd8, 64'h0,
			1'b0, 4'd0, 8'h00), 1'b1, '{64'h0, mwa_pkg::ST_CMD, 4'd0}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_AMO, mwa_pkg::AMO_SWAP, 32'd0, 4'd2, 64'h0,
			1'b0, 4'd0, 8'h00), 1'b1, '{64'h0, mwa_pkg::ST_CMD, 4'd0}});
		dir_tbl.push_back('{mk(mwa_pkg::OP_AMO, mwa_pkg::AMO_SWAP, 32'd0, 4'd4, 64'h0,
			1'b1, 4'd4, 8'hff), 1'b1, '{64'h0, mwa_pkg::ST_CMD, 4'd0}});
		// Zero-length access succeeds and touches nothing.
		dir_tbl.push_back('{mk(mwa_pkg::OP_READ, mwa_pkg::AMO_SWAP, 32'd100, 4'd0, 64'h0,
			1'b0, 4'd0, 8'h00), 1'b1, '{64'h0, mwa_pkg::ST_OK, 4'd0}});
		// Each atomic operation at one width, plus an unknown one.
		dir_tbl.push_back('{mk(mwa_pkg::OP_AMO, mwa_pkg::AMO_SWAP, 32'd0, 4'd8,
			64'hf000_0000_0000_0001, 1'b0, 4'd0, 8'h00), 1'b0, '0});
		for (int a = mwa_pkg::AMO_ADD; a <= mwa_pkg::AMO_MAXU; a++)
			dir_tbl.push_back('{mk(mwa_pkg::OP_AMO, 4'(a), (a % 2) ? 32'd3 : 32'd0,
				(a % 2) ? 4'd4 : 4'd8, 64'h8000_0001_7fff_fff3, 1'b0, 4'd0, 8'h00),
				1'b0, '0});
		dir_tbl.push_back('{mk(mwa_pkg::OP_AMO, AmoUnknown, 32'd1, 4'd4, '1, 1'b0, 4'd0,
			8'h00), 1'b0, '0});
		// Enabled writes: a short repeating pattern, then one longer than 8.
		dir_tbl.push_back('{mk(mwa_pkg::OP_WRITE, mwa_pkg::AMO_SWAP, 32'd16, 4'd8, 64'h0,
			1'b0, 4'd0, 8'h00), 1'b0, '0});
		dir_tbl.push_back('{mk(mwa_pkg::OP_WRITE, mwa_pkg::AMO_SWAP, 32'd16, 4'd8, '1,
			1'b1, 4'd3, 8'h05), 1'b0, '0});
		dir_tbl.push_back('{mk(mwa_pkg::OP_WRITE, mwa_pkg::AMO_SWAP, 32'd17, 4'd7,
			64'haaaa_aaaa_aaaa_aaaa, 1'b1, 4'd12, 8'hff), 1'b0, '0});
		dir_tbl.push_back('{mk(mwa_pkg::OP_READ, mwa_pkg::AMO_SWAP, 32'd16, 4'd8, 64'h0,
			1'b0, 4'd0, 8'h00), 1'b0, '0});

		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = dir_tbl.size() + RandomRequests;
		for (int n = 0; n < total; n++) begin
			gap = pick_gap(n);
			if (gap > 0 && start) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if (n < dir_tbl.size()) begin
				row = dir_tbl[n];
				rq  = row.rq;
			end else begin
				row.has_want = 1'b0;
				rq = random_request();
			end
			start   <= 1'b1;
			request <= rq;
			do
				@(posedge clk);
			while (busy);
			// Accepted at this edge.
			predicted = mem_apply(rq);
			pending_rsp.push_back(row.has_want ? row.want : predicted);
		end
		start <= 1'b0;

		guard = 0;
		while (pending_rsp.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);

		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			if (pending_rsp.size() != 0)
				$display("%0d results never arrived", pending_rsp.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/mwa_pkg.sv
src/mwa_front.sv
src/mwa_queue.sv
src/mwa_back.sv
src/memory_with_atomic_ops_unit.sv
tb/tb_memory_with_atomic_ops_unit.sv
